// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

    // Number of entries the queue can hold.
    localparam int SPQ_CAPACITY = 16;
    // Width of the stored-entry counter, wide enough to hold the capacity itself.
    localparam int SPQ_CNT_W    = $clog2(SPQ_CAPACITY + 1);

    localparam int ITEM_W = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 5;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // Request payload.
    typedef struct packed {
        t_req_kind         req_type;
        logic [ITEM_W-1:0] new_item;
        logic [PRIO_W-1:0] new_priority;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic [ITEM_W-1:0] out_item;
        logic [PRIO_W-1:0] out_priority;
        t_status           status;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_cmd;

endpackage

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted priority queue chain.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue.
module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_prev_entry,
    input  logic      i_prev_valid,
    input  logic      i_prev_keep,
    input  t_entry    i_next_entry,
    input  logic      i_next_valid,
    output t_entry    o_entry,
    output logic      o_valid,
    output logic      o_keep
);

    t_entry r_entry;
    logic   r_valid;
    t_entry n_entry;
    logic   n_valid;

    // This slot stays put on insert when it holds an entry of equal or higher priority.
    assign o_keep  = r_valid && (r_entry.prio >= i_cmd.new_entry.prio);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    // Next contents: hold, take the new entry, shift back from the
    // previous slot, or shift forward from the next slot.
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
                n_valid = r_valid;
            end else if (i_prev_keep) begin
                n_entry = i_cmd.new_entry;
                n_valid = 1'b1;
            end else begin
                n_entry = i_prev_entry;
                n_valid = i_prev_valid;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end
    end

    // Entry data needs no reset; the valid flag does.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a chain of spq_cell slots plus control.
// Depends on spq_pkg and spq_cell.
//
// Bounded max-priority queue of SPQ_CAPACITY entries held in a row of cells that
// is always sorted, highest priority at the front. On each request (insert or remove)
// every cell decides in parallel whether to hold, take the new entry, or shift from
// a neighbor, so a new request can be accepted every clock unless the input is stalled.
// Each request yields one result, held in an output register; the input is
// stalled only while that register is full and the output side stalls. Equal
// priorities leave in arrival order. An insert into a full queue returns status
// full, a remove from an empty queue returns status empty; neither changes the
// queue. No clearing pass is needed after reset.
module sorted_priority_queue import spq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic [SPQ_CNT_W-1:0]    r_count;
    logic [SPQ_CNT_W-1:0]    n_count;
    logic                    r_out_valid;
    t_rsp                    r_rsp;
    t_rsp                    n_rsp;
    logic                    accept;
    logic                    is_full;
    logic                    is_empty;
    t_cell_cmd               cmd;
    t_entry                  w_entry [SPQ_CAPACITY];
    logic [SPQ_CAPACITY-1:0] w_valid;
    logic [SPQ_CAPACITY-1:0] w_keep;

    // A transfer in is taken whenever the result register is free or draining.
    assign o_stall  = r_out_valid && i_stall;
    assign accept   = i_valid && !o_stall;
    assign is_full  = (r_count == SPQ_CNT_W'(SPQ_CAPACITY));
    assign is_empty = (r_count == '0);

    // Command shared by all cells.
    always_comb begin
        cmd.ins            = accept && (i_req.req_type == REQ_INSERT) && !is_full;
        cmd.rem            = accept && (i_req.req_type == REQ_REMOVE) && !is_empty;
        cmd.new_entry.item = i_req.new_item;
        cmd.new_entry.prio = i_req.new_priority;
    end

    // The chain of slots; the front slot sees an always-keeping neighbor ahead.
    for (genvar g = 0; g < SPQ_CAPACITY; g++) begin : g_cell
        t_entry prev_entry;
        logic   prev_valid;
        logic   prev_keep;
        t_entry next_entry;
        logic   next_valid;

        if (g == 0) begin : g_front
            assign prev_entry = '0;
            assign prev_valid = 1'b0;
            assign prev_keep  = 1'b1;
        end else begin : g_mid
            assign prev_entry = w_entry[g-1];
            assign prev_valid = w_valid[g-1];
            assign prev_keep  = w_keep[g-1];
        end

        if (g == SPQ_CAPACITY - 1) begin : g_back
            assign next_entry = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_entry = w_entry[g+1];
            assign next_valid = w_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_prev_entry (prev_entry),
            .i_prev_valid (prev_valid),
            .i_prev_keep  (prev_keep),
            .i_next_entry (next_entry),
            .i_next_valid (next_valid),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_keep       (w_keep[g])
        );
    end

    // Next count and the result of the accepted request.
    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + SPQ_CNT_W'(1);
        end else if (cmd.rem) begin
            n_count = r_count - SPQ_CNT_W'(1);
        end

        n_rsp              = '0;
        n_rsp.status       = ST_DONE;
        n_rsp.occupancy    = OCC_W'(n_count);
        if (i_req.req_type == REQ_INSERT) begin
            if (is_full) begin
                n_rsp.status = ST_FULL;
            end
        end else begin
            if (is_empty) begin
                n_rsp.status = ST_EMPTY;
            end else begin
                n_rsp.out_item     = w_entry[0].item;
                n_rsp.out_priority = w_entry[0].prio;
            end
        end
    end

    // Counter and output register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // The counter tracks exactly the occupied slots.
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == SPQ_CNT_W'($countones(w_valid)))
        else $error("stored count disagrees with occupied slots");

    // The counter never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SPQ_CNT_W'(SPQ_CAPACITY))
        else $error("stored count beyond capacity");

    // The front of the chain is ordered by priority.
    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_valid[0] && (w_entry[0].prio >= w_entry[1].prio)))
        else $error("front slots out of priority order");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for sorted_priority_queue: drives insert and remove
// transfers with random idling and output stalls, predicts every result in a
// shadow queue and compares field by field. Depends on spq_pkg and the RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Shadow copy of the queue contents; it predicts and checks each result.
    class queue_shadow;
        t_entry      slot [SPQ_CAPACITY];
        int unsigned held;
        t_rsp        due [$];
        int unsigned errors;
        int unsigned reported;
        int unsigned n_insert;
        int unsigned n_remove;
        int unsigned n_full;
        int unsigned n_empty;
        int unsigned n_checked;
        int unsigned peak;

        // Apply one accepted request and queue the result it must produce.
        function void take_request(t_req req);
            t_rsp        want;
            int unsigned pos;
            int unsigned k;
            want = '0;
            want.status = ST_DONE;
            if (req.req_type == REQ_INSERT) begin
                n_insert++;
                if (held >= SPQ_CAPACITY) begin
                    want.status = ST_FULL;
                    n_full++;
                end else begin
                    // The new entry goes behind everything of equal or higher priority.
                    pos = 0;
                    while (pos < held && slot[pos].prio >= req.new_priority) pos++;
                    for (k = held; k > pos; k--) slot[k] = slot[k-1];
                    slot[pos].item = req.new_item;
                    slot[pos].prio = req.new_priority;
                    held++;
                end
            end else begin
                n_remove++;
                if (held == 0) begin
                    want.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    want.out_item     = slot[0].item;
                    want.out_priority = slot[0].prio;
                    for (k = 1; k < held; k++) slot[k-1] = slot[k];
                    held--;
                end
            end
            if (held > peak) peak = held;
            want.occupancy = OCC_W'(held);
            due.push_back(want);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void match_result(t_rsp got);
            t_rsp want;
            n_checked++;
            if (due.size() == 0) begin
                errors++;
                if (reported < 10)
                    $display("result %0d with nothing pending: item %h prio %h st %0d occ %0d",
                             n_checked, got.out_item, got.out_priority, got.status,
                             got.occupancy);
                reported++;
                return;
            end
            want = due.pop_front();
            if (got.out_item !== want.out_item || got.out_priority !== want.out_priority ||
                got.status !== want.status || got.occupancy !== want.occupancy) begin
                errors++;
                if (reported < 10) begin
                    $display("mismatch at result %0d: expected item %h prio %h st %0d occ %0d",
                             n_checked, want.out_item, want.out_priority, want.status,
                             want.occupancy);
                    $display("    got item %h prio %h st %0d occ %0d",
                             got.out_item, got.out_priority, got.status, got.occupancy);
                end
                reported++;
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    // Set during a stretch of the run in which neither side idles.
    logic steady = 1'b0;

    queue_shadow shadow = new();

    sorted_priority_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Outside the steady stretch, the result side stalls in about 8 percent of cycles.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 8);
    end

    // Observe both channels at every edge; requests are applied before results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) shadow.take_request(i_req);
            if (o_valid && !i_stall) shadow.match_result(o_rsp);
        end
    end

    function automatic t_req request_of(t_req_kind kind, logic [ITEM_W-1:0] item,
                                        logic [PRIO_W-1:0] prio);
        t_req req;
        req.req_type     = kind;
        req.new_item     = item;
        req.new_priority = prio;
        return req;
    endfunction

    // Random request; priorities lean toward a few small values so that ties are common.
    function automatic t_req pick_request(int unsigned insert_pct);
        t_req        req;
        int unsigned roll;
        req.req_type = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        req.new_item = $urandom();
        roll = $urandom_range(99);
        if (roll < 40)
            req.new_priority = PRIO_W'($urandom_range(3));
        else if (roll < 45)
            req.new_priority = '0;
        else if (roll < 50)
            req.new_priority = '1;
        else
            req.new_priority = PRIO_W'($urandom_range(65535));
        return req;
    endfunction

    // Present one request, with an occasional idle gap first, and hold it until accepted.
    task automatic offer(t_req req);
        if (!steady) begin
            while ($urandom_range(99) < 8) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop sending until every predicted result has been seen.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.due.size() != 0) @(posedge i_clk);
    endtask

    // Main sequence.
    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned insert_pct;
        int unsigned waited;
        int unsigned leftover;
        logic        paused;

        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: remove from empty, extreme fields, equal priorities, fill, insert when full.
        offer(request_of(REQ_REMOVE, '1, '1));
        offer(request_of(REQ_INSERT, '0, '0));
        offer(request_of(REQ_INSERT, '1, '1));
        offer(request_of(REQ_INSERT, 32'h0000_0001, 16'h0100));
        offer(request_of(REQ_INSERT, 32'h0000_0002, 16'h0100));
        offer(request_of(REQ_INSERT, 32'h0000_0003, 16'h0100));
        repeat (SPQ_CAPACITY - 5)
            offer(request_of(REQ_INSERT, $urandom(), PRIO_W'($urandom_range(65535))));
        offer(request_of(REQ_INSERT, 32'hDEAD_BEEF, 16'h8000));
        repeat (5) offer(request_of(REQ_REMOVE, $urandom(), PRIO_W'($urandom())));
        drain_results();

        // Random bursts that lean toward filling, draining or a balanced mix.
        sent = 0;
        while (sent < 1300) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            steady <= (sent >= 300 && sent < 550);
            if (!paused && sent >= 700) begin
                drain_results();
                paused = 1'b1;
            end
            repeat (burst) offer(pick_request(insert_pct));
            sent += burst;
        end
        i_valid <= 1'b0;
        steady  <= 1'b0;

        // Let the last results arrive, then keep watching for strays before the summary.
        waited = 0;
        while (shadow.due.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        leftover = shadow.due.size();
        if (leftover != 0) $display("%0d predicted results never arrived", leftover);

        $display("run covered %0d inserts (%0d refused as full)",
                 shadow.n_insert, shadow.n_full);
        $display("and %0d removes (%0d refused as empty)",
                 shadow.n_remove, shadow.n_empty);
        $display("%0d results checked, peak occupancy %0d, %0d errors",
                 shadow.n_checked, shadow.peak, shadow.errors);
        if (shadow.errors == 0 && leftover == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #3000000;
        $display("watchdog expired before the run completed");
        $display("status: fail");
        $finish;
    end

endmodule
